// File: src/crr_pkg.sv
// Shared widths, codes and controller-to-datapath types for the coefficient row rotation core.
package crr_pkg;

  localparam int DATA_W           = 32;
  localparam int SUM_W            = 64;
  localparam int IDX_W            = 4;
  localparam int CNT_W            = 5;
  localparam int ROW_CAP          = 16;
  localparam int MAX_ORBITALS_DEF = 16;

  localparam logic [CNT_W-1:0] ORBITAL_COUNT_RESET = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_COEF = 1'b1;

  typedef struct packed {
    logic             load_en;
    logic             cap_en;
    logic             issue_en;
    logic             emit_en;
    logic             emit_last;
    logic             clear_sums;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } crr_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } crr_status_t;

endpackage

// File: src/crr_if.sv
// Valid/ready channel interfaces for the input, result and configuration ports.
interface crr_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [3:0]        k_index;
  logic [3:0]        j_index;
  logic signed [31:0] value;

  modport source (output valid, output op, output k_index, output j_index, output value,
                  input ready);
  modport sink (input valid, input op, input k_index, input j_index, input value,
                output ready);
endinterface

interface crr_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         column;
  logic signed [31:0] rotated_value;
  logic               last_of_row;
  logic               saturated;

  modport source (output valid, output column, output rotated_value, output last_of_row,
                  output saturated, input ready);
  modport sink (input valid, input column, input rotated_value, input last_of_row,
                input saturated, output ready);
endinterface

interface crr_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] orbital_count;

  modport source (output valid, output orbital_count, input ready);
  modport sink (input valid, input orbital_count, output ready);
endinterface

// File: src/crr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module crr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/crr_datapath.sv
// Datapath: rotation matrix store, multiply-accumulate pipeline, column sums and result register.
module crr_datapath
  import crr_pkg::*;
#(
  parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  crr_cmd_t                 cmd,
  output crr_status_t              status,
  input  logic [IDX_W-1:0]         in_k_index,
  input  logic [IDX_W-1:0]         in_j_index,
  input  logic signed [DATA_W-1:0] in_value,
  output logic [IDX_W-1:0]         out_column,
  output logic signed [DATA_W-1:0] out_rotated_value,
  output logic                     out_last_of_row,
  output logic                     out_saturated
);

  localparam int ROW_LIMIT = (MAX_ORBITALS < ROW_CAP) ? MAX_ORBITALS : ROW_CAP;
  localparam int SUM_IW    = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
  localparam int DEPTH     = MAX_ORBITALS * MAX_ORBITALS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_W-1:0] coef_r;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rd_data;
  logic                     s1_valid_r;
  logic [IDX_W-1:0]         s1_col_r;
  logic                     s2_valid_r;
  logic [IDX_W-1:0]         s2_col_r;
  logic signed [SUM_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]  sums_r [ROW_LIMIT];
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [SUM_W-1:0]  emit_sum;
  logic signed [DATA_W-1:0] rnd_value;
  logic                     rnd_sat;

  function automatic logic signed [SUM_W-1:0] add_sat(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      add_sat = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      add_sat = s[SUM_W-1:0];
    end
  endfunction

  assign waddr = AW'(int'(in_k_index) * MAX_ORBITALS + int'(in_j_index));
  assign raddr = AW'(int'(cmd.row) * MAX_ORBITALS + int'(cmd.col));

  crr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_en),
    .waddr (waddr),
    .wdata (in_value),
    .re    (cmd.issue_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign status.pipe_busy = s1_valid_r | s2_valid_r;

  assign acc_sum  = add_sat(sums_r[s2_col_r[SUM_IW-1:0]], prod_r);
  assign emit_sum = sums_r[cmd.col[SUM_IW-1:0]];

  // Q18.46 to Q16.16: floor by an arithmetic shift, then add the half bit.
  always_comb begin
    logic [DATA_W+2:0] t;
    t = {emit_sum[SUM_W-1], emit_sum[SUM_W-1:30]} + {{(DATA_W+2){1'b0}}, emit_sum[29]};
    if (t[DATA_W+2:DATA_W-1] != {4{t[DATA_W+2]}}) begin
      rnd_sat   = 1'b1;
      rnd_value = t[DATA_W+2] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      rnd_sat   = 1'b0;
      rnd_value = t[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int i = 0; i < ROW_LIMIT; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= cmd.issue_en;
      s2_valid_r <= s1_valid_r;
      if (cmd.clear_sums) begin
        for (int i = 0; i < ROW_LIMIT; i++) begin
          sums_r[i] <= '0;
        end
      end else if (s2_valid_r) begin
        sums_r[s2_col_r[SUM_IW-1:0]] <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      coef_r <= in_value;
    end
    s1_col_r <= cmd.col;
    s2_col_r <= s1_col_r;
    prod_r   <= coef_r * $signed(rd_data);
    if (cmd.emit_en) begin
      out_column        <= cmd.col;
      out_rotated_value <= rnd_value;
      out_last_of_row   <= cmd.emit_last;
      out_saturated     <= rnd_sat;
    end
  end

endmodule

// File: src/crr_ctrl.sv
// Controller: handshakes, row length register and the sequencing state machine.
module crr_ctrl
  import crr_pkg::*;
#(
  parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [CNT_W-1:0] cfg_orbital_count,
  output logic             cfg_ready,
  input  logic             in_valid,
  input  logic             in_op,
  input  logic [IDX_W-1:0] in_k_index,
  input  logic [IDX_W-1:0] in_j_index,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  crr_status_t      status,
  output crr_cmd_t         cmd
);

  localparam int ROW_LIMIT = (MAX_ORBITALS < ROW_CAP) ? MAX_ORBITALS : ROW_CAP;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] n_eff;
  logic             accept;
  logic             col_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign col_last  = ({1'b0, col_r} == n_r - CNT_W'(1));

  always_comb begin
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(count_r) > ROW_LIMIT) begin
      n_eff = CNT_W'(ROW_LIMIT);
    end else begin
      n_eff = count_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = cfg_valid ? cfg_orbital_count : count_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    col_nxt       = col_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd           = '0;
    cmd.row       = k_r;
    cmd.col       = col_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD) begin
            cmd.load_en = (int'(in_k_index) < MAX_ORBITALS) &&
                          (int'(in_j_index) < MAX_ORBITALS);
          end else if ({1'b0, in_k_index} < n_eff) begin
            cmd.cap_en = 1'b1;
            k_nxt      = in_k_index;
            n_nxt      = n_eff;
            col_nxt    = '0;
            state_nxt  = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        cmd.issue_en = 1'b1;
        col_nxt      = col_r + IDX_W'(1);
        if (col_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          col_nxt = '0;
          if ({1'b0, k_r} == n_r - CNT_W'(1)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit_en    = 1'b1;
          cmd.emit_last  = col_last;
          out_valid_nxt  = 1'b1;
          col_nxt        = col_r + IDX_W'(1);
          if (col_last) begin
            cmd.clear_sums = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= ORBITAL_COUNT_RESET;
      out_valid_r <= 1'b0;
      n_r         <= CNT_W'(1);
      k_r         <= '0;
      col_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      col_r       <= col_nxt;
    end
  end

endmodule

// File: src/coefficient_row_rotation_core.sv
// Top level of the coefficient row rotation core: a streaming row-by-matrix multiply.
//
// Load the rotation matrix with op 0 transfers (one entry each), then stream
// the elements of a basis row with op 1. Each element is multiplied by its matrix row through a
// single multiply-accumulate unit that reads one matrix entry per cycle from the matrix RAM,
// and no new input is taken until its row is done; n is the effective row length. An element
// with the last row index (n - 1) then emits n results, one column per transfer, at one per cycle
// when the result side is ready; the final one carries last_of_row and the column sums are cleared.
// A new input transfer may be taken while the final result still waits in the output register.
// The matrix store has no reset and needs no clearing pass; the sums are cleared by reset.
module coefficient_row_rotation_core
  import crr_pkg::*;
#(
  parameter int MAX_ORBITALS = MAX_ORBITALS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  crr_cfg_if.sink  cfg_ch,
  crr_in_if.sink   in_ch,
  crr_out_if.source out_ch
);

  crr_cmd_t    cmd;
  crr_status_t status;

  crr_ctrl #(
    .MAX_ORBITALS (MAX_ORBITALS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_ch.valid),
    .cfg_orbital_count (cfg_ch.orbital_count),
    .cfg_ready         (cfg_ch.ready),
    .in_valid          (in_ch.valid),
    .in_op             (in_ch.op),
    .in_k_index        (in_ch.k_index),
    .in_j_index        (in_ch.j_index),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .status            (status),
    .cmd               (cmd)
  );

  crr_datapath #(
    .MAX_ORBITALS (MAX_ORBITALS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_k_index        (in_ch.k_index),
    .in_j_index        (in_ch.j_index),
    .in_value          (in_ch.value),
    .out_column        (out_ch.column),
    .out_rotated_value (out_ch.rotated_value),
    .out_last_of_row   (out_ch.last_of_row),
    .out_saturated     (out_ch.saturated)
  );

  // New input is only taken once the multiply-accumulate pipeline has drained.
  a_ready_drained : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !status.pipe_busy)
    else $error("input ready while the accumulate pipeline is busy");

  a_issue_emit_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.issue_en && cmd.emit_en))
    else $error("accumulate and emit in the same cycle");

  a_clear_last : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_sums |=> out_ch.valid && out_ch.last_of_row)
    else $error("sums cleared without a final result being presented");

  a_load_on_transfer : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en |-> in_ch.valid && in_ch.ready && (in_ch.op == OP_LOAD))
    else $error("matrix write without a load transfer");

endmodule
